@@ hw/rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants, types and command/status bundles for the glyph blitter.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // Panel and font store geometry
  localparam int PANEL_WIDTH     = 64;
  localparam int PANEL_HEIGHT    = 16;
  localparam int GLYPH_COUNT     = 96;
  localparam int MAX_FONT_HEIGHT = 8;
  localparam int MAX_WIDTH       = 8;
  localparam int STORE_DEPTH     = GLYPH_COUNT * MAX_FONT_HEIGHT;
  localparam int STORE_AW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Printable character window
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd127;

  // Beat widths
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  // Item kinds (s_tuser)
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Register indexes
  localparam logic REG_FONT_WIDTH  = 1'b0;
  localparam logic REG_FONT_HEIGHT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic calc;   // clip geometry, latch base address, clear counters
    logic rd;     // read current glyph row from the store
    logic step;   // examine one glyph bit and advance column/row
    logic flush;  // send the held pixel as the final beat
  } gbs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;        // draw yields nothing
    logic col_last;     // current bit is the last of its row
    logic row_last;     // current row is the last to draw
    logic stall;        // a step now would overrun the output register
    logic flush_stall;  // the final beat cannot be handed over yet
  } gbs_stat_t;

endpackage

@@ hw/rtl/glyph_blitter_serpentine_unit.sv @@
// ----------------------------------------------------------------------------
// glyph_blitter_serpentine_unit
// Bitmap-font glyph blitter for a serpentine-wired 16-row LED panel.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents
//  -------  ---  -------------------------------------------------------------
//  s_*      in   load (font row write) or draw (one glyph), kind on s_tuser
//  m_*      out  one pixel write: strip index and colour, m_tlast on final
//  cfg_*    in   font_width (index 0), font_height (index 1)
//
//  A load is written into the font store as it is accepted. A draw clips the
//  glyph, reads the store once per glyph row, scans one bit per cycle unless
//  held by an output stall, and ends with a flush of the held pixel.
//  Output stalls hold the scan only when a second pixel is ready to go.
//  rst is synchronous; font store contents are undefined until loaded.
//
module glyph_blitter_serpentine_unit
  import gbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [9:0] row_address, [25:10] row_bits, [33:26] glyph_code, [40:34] x_pos,
  // [45:41] y_pos, [49:46] first_line, [53:50] line_count, [56:54] left_shift,
  // [80:57] color, [87:81] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,    // [0] kind
  // pixel stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  // configuration
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [3:0]             cfg_data
);

  gbs_cmd_t  cmd;
  gbs_stat_t stat;
  logic      in_beat;

  // Only idle takes items, so a beat is a complete handover
  assign in_beat = s_tvalid && s_tready;

  gbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_beat),
    .in_kind   (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ hw/rtl/gbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: accepts items, then walks rows (read) and bits (scan) of a glyph.
// ----------------------------------------------------------------------------
module gbs_ctrl
  import gbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tuser,
  output logic      s_tready,
  input  gbs_stat_t stat,
  output gbs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == KIND_DRAW) state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.empty ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stat.stall) begin
          cmd.step = 1'b1;
          if (stat.col_last) state_next = stat.row_last ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!stat.flush_stall) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);

  // A flush that is not held back must end the draw
  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && !stat.flush_stall) |=> (state == ST_IDLE))
    else $error("flush did not return to idle");

endmodule

@@ hw/rtl/gbs_datapath.sv @@
// ----------------------------------------------------------------------------
// gbs_datapath
// Font store, draw geometry, bit scanner, held pixel and output register.
// ----------------------------------------------------------------------------
module gbs_datapath
  import gbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item side
  input  logic                   in_beat,
  input  logic                   in_kind,
  input  logic [IN_TDATA_W-1:0]  in_data,
  // configuration
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [3:0]             cfg_data,
  // result side
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_last,
  // control
  input  gbs_cmd_t               cmd,
  output gbs_stat_t              stat
);

  // Input fields
  logic [9:0]        f_row_address;
  logic [15:0]       f_row_bits;
  logic [7:0]        f_glyph_code;
  logic signed [6:0] f_x_pos;
  logic signed [4:0] f_y_pos;
  logic [3:0]        f_first_line;
  logic [3:0]        f_line_count;
  logic [2:0]        f_left_shift;
  logic [23:0]       f_color;

  assign f_row_address = in_data[9:0];
  assign f_row_bits    = in_data[25:10];
  assign f_glyph_code  = in_data[33:26];
  assign f_x_pos       = in_data[40:34];
  assign f_y_pos       = in_data[45:41];
  assign f_first_line  = in_data[49:46];
  assign f_line_count  = in_data[53:50];
  assign f_left_shift  = in_data[56:54];
  assign f_color       = in_data[80:57];

  // Geometry registers
  logic [3:0] font_width, font_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_width  <= 4'd8;
      font_height <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_WIDTH:  font_width  <= cfg_data;
        REG_FONT_HEIGHT: font_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Font store
  logic [15:0] font_mem [STORE_DEPTH];
  logic [11:0] wr_addr_w;
  logic [15:0] row_q;
  logic [11:0] rd_addr_w;

  assign wr_addr_w = 12'(f_row_address);

  always_ff @(posedge clk) begin
    if (in_beat && in_kind == KIND_LOAD && wr_addr_w < 12'(STORE_DEPTH))
      font_mem[wr_addr_w[STORE_AW-1:0]] <= f_row_bits;
    if (cmd.rd)
      row_q <= font_mem[rd_addr_w[STORE_AW-1:0]];
  end

  // Draw job, captured on accept
  logic [7:0]        code_q;
  logic signed [6:0] x_q;
  logic signed [4:0] y_q;
  logic [3:0]        first_q, count_q;
  logic [2:0]        shift_q;
  logic [23:0]       color_q;

  always_ff @(posedge clk) begin
    if (in_beat && in_kind == KIND_DRAW) begin
      code_q  <= f_glyph_code;
      x_q     <= f_x_pos;
      y_q     <= f_y_pos;
      first_q <= f_first_line;
      count_q <= f_line_count;
      shift_q <= f_left_shift;
      color_q <= f_color;
    end
  end

  // Clipping
  logic [6:0]        gidx;
  logic              code_ok;
  logic [3:0]        w_eff, h_eff;
  logic [4:0]        first_plus;
  logic signed [5:0] lines1;
  logic signed [6:0] bottom;
  logic signed [6:0] lines2;
  logic [10:0]       base_c;

  always_comb begin
    gidx    = 7'(code_q - CODE_FIRST);
    code_ok = (code_q >= CODE_FIRST) && (code_q <= CODE_LAST)
              && ({1'b0, gidx} < 8'(GLYPH_COUNT));
    w_eff   = (font_width > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : font_width;
    h_eff   = (font_height > 4'(MAX_FONT_HEIGHT)) ? 4'(MAX_FONT_HEIGHT) : font_height;
    first_plus = 5'(first_q) + 5'(count_q);
    if (first_plus > 5'(h_eff)) lines1 = $signed(6'(h_eff)) - $signed(6'(first_q));
    else                        lines1 = $signed(6'(count_q));
    bottom = 7'(lines1) + 7'(y_q);
    if (bottom > 7'sd16) lines2 = 7'sd16 - 7'(y_q);
    else                 lines2 = 7'(lines1);
    base_c = 11'(gidx) * 11'(h_eff) + 11'(first_q);
  end

  assign stat.empty = !code_ok || (w_eff == 4'd0) || (h_eff == 4'd0) || (lines1 <= 6'sd0);

  // Scan counters
  logic [3:0]  lines_q, w_q;
  logic [10:0] base_q;
  logic [2:0]  i_q, j_q;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      lines_q <= lines2[3:0];
      w_q     <= w_eff;
      base_q  <= base_c;
      i_q     <= '0;
      j_q     <= '0;
    end else if (cmd.step) begin
      if (stat.col_last) begin
        j_q <= '0;
        i_q <= i_q + 3'd1;
      end else begin
        j_q <= j_q + 3'd1;
      end
    end
  end

  assign rd_addr_w     = 12'(base_q) + 12'(i_q);
  assign stat.col_last = ({1'b0, j_q} == w_q - 4'd1);
  assign stat.row_last = ({1'b0, i_q} == lines_q - 4'd1);

  // Bit test and panel check
  logic [15:0]       row_sh;
  logic [2:0]        bit_pos;
  logic signed [8:0] cx;
  logic signed [5:0] cy;
  logic              hit;
  logic [9:0]        pix_idx;

  always_comb begin
    row_sh  = 16'(row_q << shift_q);
    bit_pos = 3'(w_q - 4'd1 - {1'b0, j_q});
    cx      = 9'(x_q) + 9'(j_q);
    cy      = 6'(y_q) + 6'(i_q);
    hit     = row_sh[bit_pos]
              && !cx[8] && ({1'b0, cx[7:0]} < 9'(PANEL_WIDTH))
              && !cy[5] && (cy[4:0] < 5'(PANEL_HEIGHT));
    // odd columns run bottom-up
    pix_idx = {cx[5:0], (cx[0] ? ~cy[3:0] : cy[3:0])};
  end

  // Held pixel: the last beat is only known once the scan ends
  logic                   pend_valid;
  logic [9:0]             pend_idx;
  logic                   load_out;
  logic                   step_hit;
  logic                   out_busy;

  assign out_busy         = out_valid && !out_ready;
  assign stat.stall       = hit && pend_valid && out_busy;
  assign stat.flush_stall = pend_valid && out_busy;
  assign step_hit         = cmd.step && hit;
  assign load_out         = (step_hit && pend_valid) || (cmd.flush && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (step_hit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_hit) pend_idx <= pix_idx;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {6'd0, color_q[7:0], color_q[15:8], color_q[23:16], pend_idx};
      out_last <= cmd.flush;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("output beat overwritten");

  a_rd_in_store: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (rd_addr_w < 12'(STORE_DEPTH)))
    else $error("font store read out of range");

  a_lines_clipped: assert property (@(posedge clk) disable iff (rst)
    (cmd.calc && !stat.empty) |=>
      (lines_q != 4'd0) && (lines_q <= 4'(MAX_FONT_HEIGHT)))
    else $error("clipped line count out of range");

endmodule
